[src/far_pkg.sv]
`timescale 1ns / 1ps
package far_pkg;
  localparam int unsigned DefOperandWidth = 16;
  localparam int unsigned ResWidth = 32;

  typedef enum logic [2:0] {
    MODE_SUB = 3'd0,
    MODE_MUL = 3'd1,
    MODE_DIV = 3'd2,
    MODE_INC = 3'd3,
    MODE_DEC = 3'd4,
    MODE_RED = 3'd5
  } mode_t;

  localparam logic [0:0] ADDR_REDUCE_ENABLE = 1'b0;

  typedef struct packed {
    logic [ResWidth-1:0] num;
    logic [ResWidth-1:0] den;
    logic                bad;
    logic                reduce;
  } work_t;

  function automatic logic [ResWidth-1:0] mag(input logic [ResWidth-1:0] v);
    mag = v[ResWidth-1] ? (~v + 1'b1) : v;
  endfunction
endpackage

[src/fraction_arithmetic_reduce.sv]
`timescale 1ns / 1ps
// Rational arithmetic with gcd reduction.
// Input queue side: push with mode, a_num, a_den, b_num, b_den while full is low.
// Result queue side: while empty is low res_num, res_den, status show the result;
// pop takes it.
// Front unit forms the cross products with a shared multiplier in S_MUL1 and S_MUL2
// (subtract adds a second multiplier for the denominator); full is high while an
// item is in the front and while it waits in S_DONE for the back.
// No separate handoff register: the front holds its item until the back takes it.
// Back unit runs a binary gcd (one halving or subtract-and-halve a cycle) and,
// when the gcd exceeds 1, two restoring divides (numerator, then denominator).
// A bad item, or one with reduce off, goes straight to the result; a reduced one
// shows its result once the gcd and any divides are done.
// The front takes a new item while the back still works or holds a result.
// A stalled receiver holds the result; the front then fills and full rises.
// Reset empties both units and sets reduce_enable to 1.
// reduce_enable lives at byte address 0 of the APB port.
module fraction_arithmetic_reduce import far_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = DefOperandWidth
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [2:0]                      mode,
  input  logic signed [OPERAND_WIDTH-1:0] a_num,
  input  logic signed [OPERAND_WIDTH-1:0] a_den,
  input  logic signed [OPERAND_WIDTH-1:0] b_num,
  input  logic signed [OPERAND_WIDTH-1:0] b_den,
  output logic                            empty,
  input  logic                            pop,
  output logic signed [ResWidth-1:0]      res_num,
  output logic signed [ResWidth-1:0]      res_den,
  output logic                            status,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [0:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  logic reduce_enable, in_ready, wv, wr;
  work_t wd;

  assign pready = 1'b1;
  assign full = !in_ready;
  assign prdata = {31'd0, reduce_enable};

  always_ff @(posedge clk) begin
    if (rst) reduce_enable <= 1'b1;
    else if (psel && penable && pwrite && paddr == ADDR_REDUCE_ENABLE)
      reduce_enable <= pwdata[0];
  end

  far_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
    .clk, .rst, .in_valid(push), .in_ready, .mode, .a_num, .a_den, .b_num, .b_den,
    .reduce_enable, .wv, .wd, .wr
  );

  far_back u_back (
    .clk, .rst, .wv, .wd, .wr, .empty, .pop,
    .res_num, .res_den, .status
  );
endmodule

[src/far_front.sv]
`timescale 1ns / 1ps
module far_front import far_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = DefOperandWidth
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [2:0]                      mode,
  input  logic signed [OPERAND_WIDTH-1:0] a_num,
  input  logic signed [OPERAND_WIDTH-1:0] a_den,
  input  logic signed [OPERAND_WIDTH-1:0] b_num,
  input  logic signed [OPERAND_WIDTH-1:0] b_den,
  input  logic                            reduce_enable,
  output logic                            wv,
  output work_t                           wd,
  input  logic                            wr
);
  typedef enum logic [1:0] {S_IDLE, S_MUL1, S_MUL2, S_DONE} state_t;
  state_t state;
  logic [2:0] md;
  logic [ResWidth-1:0] an, ad, bn, bd, p0, p1, mx, my, prod;
  logic red;

  assign prod = mx * my;
  assign in_ready = (state == S_IDLE);
  assign wv = (state == S_DONE);

  always_comb begin
    mx = an;
    my = bd;
    case (md)
      MODE_SUB: begin
        mx = (state == S_MUL1) ? an : bn;
        my = (state == S_MUL1) ? bd : ad;
      end
      MODE_MUL: begin
        mx = (state == S_MUL1) ? an : ad;
        my = (state == S_MUL1) ? bn : bd;
      end
      MODE_DIV: begin
        mx = (state == S_MUL1) ? an : ad;
        my = (state == S_MUL1) ? bd : bn;
      end
      default: begin
        mx = an;
        my = bd;
      end
    endcase
  end

  always_comb begin
    wd.reduce = red;
    unique case (md) inside
      MODE_SUB: begin wd.num = p0 - p1; wd.den = ad * bd; end
      MODE_MUL, MODE_DIV: begin wd.num = p0; wd.den = p1; end
      MODE_INC: begin wd.num = an + ad; wd.den = ad; end
      MODE_DEC: begin wd.num = an - ad; wd.den = ad; end
      default: begin wd.num = an; wd.den = ad; end
    endcase
    wd.bad = (ad == '0) || (wd.den == '0) ||
             ((md == MODE_SUB || md == MODE_MUL || md == MODE_DIV) && bd == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          md <= mode;
          an <= ResWidth'($signed(a_num));
          ad <= ResWidth'($signed(a_den));
          bn <= ResWidth'($signed(b_num));
          bd <= ResWidth'($signed(b_den));
          red <= reduce_enable;
          state <= S_MUL1;
        end
        S_MUL1: begin p0 <= prod; state <= S_MUL2; end
        S_MUL2: begin
          p1 <= prod;
          state <= S_DONE;
        end
        S_DONE: if (wr) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[src/far_back.sv]
`timescale 1ns / 1ps
module far_back import far_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                wv,
  input  work_t               wd,
  output logic                wr,
  output logic                empty,
  input  logic                pop,
  output logic [ResWidth-1:0] res_num,
  output logic [ResWidth-1:0] res_den,
  output logic                status
);
  localparam int unsigned CntW = $clog2(ResWidth + 1);
  localparam int unsigned ShfW = $clog2(ResWidth);

  typedef enum logic [2:0] {S_IDLE, S_GCD, S_DIV1, S_DIV2, S_OUT} state_t;
  state_t state;
  logic [ResWidth-1:0] x, y, g, gfin, rem, quo, dvd, vnum, vden, qn;
  logic [ResWidth:0] sub;
  logic [CntW-1:0] cnt;
  logic [ShfW-1:0] shf;

  assign wr = (state == S_IDLE);
  assign empty = (state != S_OUT);
  assign gfin = (x | y) << shf;
  assign sub = {1'b0, rem[ResWidth-2:0], dvd[ResWidth-1]} - {1'b0, g};
  assign qn = {quo[ResWidth-2:0], ~sub[ResWidth]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (wv) begin
          vnum <= wd.num;
          vden <= wd.den;
          status <= wd.bad;
          x <= mag(wd.num);
          y <= mag(wd.den);
          shf <= '0;
          state <= (wd.bad || !wd.reduce) ? S_OUT : S_GCD;
        end
        S_GCD: begin
          if (x == '0 || y == '0) begin
            g <= gfin;
            state <= (gfin > ResWidth'(1)) ? S_DIV1 : S_OUT;
            res_num <= vnum;
            res_den <= vden;
            rem <= '0;
            quo <= '0;
            dvd <= mag(vnum);
            cnt <= '0;
          end else if (!x[0] && !y[0]) begin
            x <= x >> 1;
            y <= y >> 1;
            shf <= shf + 1'b1;
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (x >= y) begin
            x <= (x - y) >> 1;
          end else begin
            y <= (y - x) >> 1;
          end
        end
        S_DIV1, S_DIV2: begin
          if (cnt == CntW'(ResWidth - 1)) begin
            cnt <= '0;
            rem <= '0;
            quo <= '0;
            if (state == S_DIV1) begin
              res_num <= vnum[ResWidth-1] ? (~qn + 1'b1) : qn;
              dvd <= mag(vden);
              state <= S_DIV2;
            end else begin
              res_den <= vden[ResWidth-1] ? (~qn + 1'b1) : qn;
              state <= S_OUT;
            end
          end else begin
            rem <= sub[ResWidth] ? {rem[ResWidth-2:0], dvd[ResWidth-1]} : sub[ResWidth-1:0];
            dvd <= dvd << 1;
            quo <= qn;
            cnt <= cnt + 1'b1;
          end
        end
        S_OUT: if (pop) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (state == S_IDLE && wv) begin
        res_num <= wd.num;
        res_den <= wd.den;
      end
    end
  end

  a_status: assert property (@(posedge clk) disable iff (rst)
    (!empty && status) |-> (res_den == vden)) else $error("bad item altered");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(res_num) && $stable(res_den)))
    else $error("result moved");
  a_wr: assert property (@(posedge clk) disable iff (rst)
    (wr && wv) |=> !wr) else $error("back took two");
endmodule

[dv/fraction_arithmetic_reduce_tb.sv]
`timescale 1ns / 1ps
module fraction_arithmetic_reduce_tb;
  import far_pkg::*;

  localparam int unsigned W = DefOperandWidth;
  localparam int unsigned WdogLimit = 20000;

  typedef struct packed {
    logic [ResWidth-1:0] num;
    logic [ResWidth-1:0] den;
    logic                status;
  } fraction_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  logic [2:0]          mode = MODE_SUB;
  logic signed [W-1:0] a_num = '0;
  logic signed [W-1:0] a_den = '0;
  logic signed [W-1:0] b_num = '0;
  logic signed [W-1:0] b_den = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic signed [ResWidth-1:0] res_num;
  logic signed [ResWidth-1:0] res_den;
  logic                status;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [0:0]          paddr = ADDR_REDUCE_ENABLE;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  fraction_t pending_fractions[$];
  logic      reduce_on = 1'b1;
  int        err_cnt = 0;
  int        idle_cycles = 0;
  int        pop_hold = 0;

  fraction_arithmetic_reduce #(.OPERAND_WIDTH(W)) dut (.*);

  always #5 clk = ~clk;

  function automatic logic [31:0] sext(input logic [W-1:0] v);
    return {{(32-W){v[W-1]}}, v};
  endfunction

  function automatic logic [31:0] magnitude(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic fraction_t predict_fraction(input logic [2:0] m,
      input logic [W-1:0] an_i, input logic [W-1:0] ad_i,
      input logic [W-1:0] bn_i, input logic [W-1:0] bd_i);
    logic [31:0] an, ad, bn, bd, rn, rd, x, y, t, q;
    logic bad;
    fraction_t r;
    an = sext(an_i);
    ad = sext(ad_i);
    bn = sext(bn_i);
    bd = sext(bd_i);
    bad = (ad == 0);
    case (m)
      MODE_SUB: begin
        rn = an * bd - bn * ad;
        rd = ad * bd;
        bad = bad || (bd == 0);
      end
      MODE_MUL: begin
        rn = an * bn;
        rd = ad * bd;
        bad = bad || (bd == 0);
      end
      MODE_DIV: begin
        rn = an * bd;
        rd = ad * bn;
        bad = bad || (bd == 0);
      end
      MODE_INC: begin
        rn = an + ad;
        rd = ad;
      end
      MODE_DEC: begin
        rn = an - ad;
        rd = ad;
      end
      default: begin
        rn = an;
        rd = ad;
      end
    endcase
    if (rd == 0) bad = 1'b1;
    if (!bad && reduce_on) begin
      x = magnitude(rn);
      y = magnitude(rd);
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      if (x > 1) begin
        q = magnitude(rn) / x;
        rn = rn[31] ? (32'd0 - q) : q;
        q = magnitude(rd) / x;
        rd = rd[31] ? (32'd0 - q) : q;
      end
    end
    r.num = rn;
    r.den = rd;
    r.status = bad;
    return r;
  endfunction

  task automatic send_fraction(input logic [2:0] m, input logic [W-1:0] an,
      input logic [W-1:0] ad, input logic [W-1:0] bn, input logic [W-1:0] bd,
      input bit gaps);
    int r, gap;
    @(negedge clk);
    push <= 1'b1;
    mode <= m;
    a_num <= an;
    a_den <= ad;
    b_num <= bn;
    b_den <= bd;
    do @(posedge clk); while (full);
    pending_fractions.push_back(predict_fraction(m, an, ad, bn, bd));
    gap = 0;
    if (gaps) begin
      r = $urandom_range(0, 99);
      if (r < 50) gap = 0;
      else if (r < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(20, 80);
    end
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    push <= 1'b0;
    while (pending_fractions.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reduce_enable(input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_REDUCE_ENABLE;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    reduce_on = value[0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    psel <= 1'b1;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[0] !== reduce_on) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("reduce_enable readback: expected %0b actual %0b", reduce_on, prdata[0]);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [W-1:0] rand_operand(input bit allow_zero);
    int k;
    k = $urandom_range(0, 99);
    if (allow_zero && k < 4) return '0;
    if (k < 40) return W'($signed($urandom_range(0, 40)) - 20);
    if (k < 50) begin
      case ($urandom_range(0, 3))
        0: return {1'b1, {(W-1){1'b0}}};
        1: return {1'b0, {(W-1){1'b1}}};
        2: return '1;
        default: return W'(1);
      endcase
    end
    if (k < 70) return W'($urandom_range(1, 360) * ($urandom_range(0, 1) ? 1 : -1) * 12);
    return W'($urandom);
  endfunction

  task automatic test_directed();
    logic [W-1:0] mn, mx;
    mn = {1'b1, {(W-1){1'b0}}};
    mx = {1'b0, {(W-1){1'b1}}};
    for (int m = 0; m < 8; m++) send_fraction(3'(m), W'(6), W'(-8), W'(9), W'(12), 1'b0);
    send_fraction(MODE_SUB, mn, mn, mx, mn, 1'b0);
    send_fraction(MODE_MUL, mn, mn, mn, mn, 1'b0);
    send_fraction(MODE_DIV, mx, mn, mx, mx, 1'b0);
    send_fraction(MODE_MUL, mn, W'(1), W'(1), W'(1), 1'b0);
    send_fraction(MODE_SUB, W'(3), '0, W'(2), W'(5), 1'b0);
    send_fraction(MODE_MUL, W'(3), W'(5), W'(2), '0, 1'b0);
    send_fraction(MODE_DIV, W'(3), W'(5), '0, W'(7), 1'b0);
    send_fraction(MODE_INC, W'(4), '0, mx, mx, 1'b0);
    send_fraction(MODE_RED, '0, W'(-15), '0, '0, 1'b0);
    send_fraction(MODE_RED, W'(-15), W'(-25), mn, mx, 1'b0);
    send_fraction(MODE_DEC, mx, mn, W'(1), W'(1), 1'b0);
    send_fraction(MODE_INC, mx, mx, W'(0), W'(0), 1'b0);
    send_fraction(3'd7, '1, '1, '1, '1, 1'b0);
    send_fraction(MODE_SUB, W'(5), W'(7), W'(5), W'(7), 1'b0);
    drain_results();
  endtask

  task automatic test_random(input int count);
    logic [2:0] m;
    for (int i = 0; i < count; i++) begin
      m = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      send_fraction(m, rand_operand(1'b0), rand_operand(1'b1),
                    rand_operand(1'b1), rand_operand(1'b1), 1'b1);
    end
    drain_results();
  endtask

  always @(negedge clk) begin
    logic next_pop;
    if (pop_hold > 0) begin
      pop_hold--;
      next_pop = 1'b0;
    end else if ($urandom_range(0, 99) < 4) begin
      pop_hold = $urandom_range(20, 120);
      next_pop = 1'b0;
    end else begin
      next_pop = ($urandom_range(0, 99) < 75);
    end
    pop <= next_pop;
  end

  always @(posedge clk) begin
    fraction_t exp_f;
    if (!rst && pop && !empty) begin
      if (pending_fractions.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected result: num %0d den %0d status %0b", res_num, res_den, status);
      end else begin
        exp_f = pending_fractions.pop_front();
        if (res_num !== exp_f.num || res_den !== exp_f.den || status !== exp_f.status) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: expected %0d/%0d st %0b, actual %0d/%0d st %0b",
                     $signed(exp_f.num), $signed(exp_f.den), exp_f.status,
                     res_num, res_den, status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(400);
    write_reduce_enable({31'($urandom_range(0, 32'h7fff)), 1'b0});
    test_random(200);
    write_reduce_enable(32'hffff_ffff);
    test_random(250);
    if (pending_fractions.size() == 0 && err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

[fraction_arithmetic_reduce.f]
src/far_pkg.sv
src/far_front.sv
src/far_back.sv
src/fraction_arithmetic_reduce.sv
dv/fraction_arithmetic_reduce_tb.sv
